// File: rtl/dlr_pkg.sv
// Package for the DDA line rasterizer.
// Holds the sequencer state type and the request command codes. It depends on nothing else.
`default_nettype none

package dlr_pkg;

   // Sequencer states, one-hot.
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_DIVIDE = 2'b10
   } state_type;

   // Command codes carried on the request channel.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_NEXT = 1'b1;

endpackage : dlr_pkg

`default_nettype wire

// File: rtl/dda_line_rasterizer.sv
// DDA line rasterizer top level; it depends on dlr_pkg for the state type and command codes.
// A load transfer is accepted, then the shared restoring divider runs, x axis then y axis,
// one quotient bit per cycle; a zero-length line skips it. Next-point transfers are taken
// one per cycle unless rsp_stall holds a full response register, and each result is
// registered and shows on the response port the cycle after its request is taken.
// Reset is synchronous and active high; it clears the sequencer, line state and valid.
`default_nettype none

module dda_line_rasterizer
   import dlr_pkg::*;
#(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_command,
   input  wire logic [COORD_BITS-1:0] req_x_start,
   input  wire logic [COORD_BITS-1:0] req_y_start,
   input  wire logic [COORD_BITS-1:0] req_x_end,
   input  wire logic [COORD_BITS-1:0] req_y_end,
   // Response channel.
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [COORD_BITS-1:0]      rsp_point_x,
   output logic [COORD_BITS-1:0]      rsp_point_y,
   output logic                       rsp_last
);

   // Accumulators hold the position with FRAC_BITS fraction bits. Increments are
   // two's complement values between -1.0 and +1.0, so they need two integer bits.
   localparam int ACC_W  = COORD_BITS + FRAC_BITS;
   localparam int STEP_W = FRAC_BITS + 2;
   localparam int QUOT_W = FRAC_BITS + 1;
   localparam int PL_W   = COORD_BITS + 1;
   localparam int CNT_W  = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAC_BITS);

   state_type              state_ff, state_in;
   logic [ACC_W-1:0]       x_accum_ff, x_accum_in;
   logic [ACC_W-1:0]       y_accum_ff, y_accum_in;
   logic [STEP_W-1:0]      x_step_ff, x_step_in;
   logic [STEP_W-1:0]      y_step_ff, y_step_in;
   logic [PL_W-1:0]        points_left_ff, points_left_in;

   // Divider operands and working registers. The quotient register keeps all but the
   // newest bit, which comes straight from the current compare.
   logic [COORD_BITS-1:0]  mag_y_ff, mag_y_in;
   logic                   neg_x_ff, neg_x_in;
   logic                   neg_y_ff, neg_y_in;
   logic [COORD_BITS-1:0]  rem_ff, rem_in;
   logic [QUOT_W-2:0]      quot_ff, quot_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   axis_ff, axis_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]  rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0]  rsp_y_ff, rsp_y_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   req_take;
   logic [COORD_BITS-1:0]  adx, ady, steps;
   logic [COORD_BITS:0]    trial;
   logic                   trial_ge;
   logic [QUOT_W-1:0]      quot_next;
   logic [STEP_W-1:0]      quot_ext;
   logic [STEP_W-1:0]      step_value;
   logic                   step_neg;

   // The block takes a transfer only when the sequencer is idle and the response
   // register is free or being emptied in this same cycle.
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   // Endpoint differences for a load.
   always_comb begin
      adx   = (req_x_end >= req_x_start) ? (req_x_end - req_x_start)
                                         : (req_x_start - req_x_end);
      ady   = (req_y_end >= req_y_start) ? (req_y_end - req_y_start)
                                         : (req_y_start - req_y_end);
      steps = (adx > ady) ? adx : ady;
   end

   // One restoring division step. The first step yields the integer bit of the
   // quotient without a shift; the remaining FRAC_BITS steps shift the remainder
   // left first. The divisor is the step count, parked in points_left during setup.
   always_comb begin
      if (cnt_ff == '0) begin
         trial = {1'b0, rem_ff};
      end else begin
         trial = {rem_ff, 1'b0};
      end
      trial_ge   = trial >= {1'b0, points_left_ff[COORD_BITS-1:0]};
      quot_next  = {quot_ff, trial_ge};
      quot_ext   = {1'b0, quot_next};
      step_neg   = axis_ff ? neg_y_ff : neg_x_ff;
      step_value = step_neg ? (~quot_ext + STEP_W'(1)) : quot_ext;
   end

   always_comb begin
      state_in       = state_ff;
      x_accum_in     = x_accum_ff;
      y_accum_in     = y_accum_ff;
      x_step_in      = x_step_ff;
      y_step_in      = y_step_ff;
      points_left_in = points_left_ff;
      mag_y_in       = mag_y_ff;
      neg_x_in       = neg_x_ff;
      neg_y_in       = neg_y_ff;
      rem_in         = rem_ff;
      quot_in        = quot_ff;
      cnt_in         = cnt_ff;
      axis_in        = axis_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_command == CMD_LOAD)) begin
               // A load replaces any line in progress at once.
               x_accum_in     = {req_x_start, {FRAC_BITS{1'b0}}};
               y_accum_in     = {req_y_start, {FRAC_BITS{1'b0}}};
               points_left_in = {1'b0, steps};
               mag_y_in       = ady;
               neg_x_in       = req_x_end < req_x_start;
               neg_y_in       = req_y_end < req_y_start;
               rem_in         = adx;
               cnt_in         = '0;
               axis_in        = 1'b0;
               if (steps == '0) begin
                  // Zero-length line: nothing to divide, nothing to emit.
                  x_step_in = '0;
                  y_step_in = '0;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end else if (req_take && (points_left_ff != '0)) begin
               // Next point: emit the truncated position, then advance.
               rsp_valid_in   = 1'b1;
               rsp_x_in       = x_accum_ff[ACC_W-1:FRAC_BITS];
               rsp_y_in       = y_accum_ff[ACC_W-1:FRAC_BITS];
               rsp_last_in    = points_left_ff == PL_W'(1);
               x_accum_in     = x_accum_ff
                              + {{(ACC_W-STEP_W){x_step_ff[STEP_W-1]}}, x_step_ff};
               y_accum_in     = y_accum_ff
                              + {{(ACC_W-STEP_W){y_step_ff[STEP_W-1]}}, y_step_ff};
               points_left_in = points_left_ff - PL_W'(1);
            end
         end
         ST_DIVIDE: begin
            rem_in  = trial_ge ? COORD_BITS'(trial - {1'b0, points_left_ff[COORD_BITS-1:0]})
                               : COORD_BITS'(trial);
            quot_in = quot_next[QUOT_W-2:0];
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_BIT) begin
               cnt_in = '0;
               if (axis_ff) begin
                  y_step_in = step_value;
                  state_in  = ST_IDLE;
               end else begin
                  x_step_in = step_value;
                  rem_in    = mag_y_ff;
                  axis_in   = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         x_accum_ff     <= '0;
         y_accum_ff     <= '0;
         x_step_ff      <= '0;
         y_step_ff      <= '0;
         points_left_ff <= '0;
         cnt_ff         <= '0;
         axis_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         x_accum_ff     <= x_accum_in;
         y_accum_ff     <= y_accum_in;
         x_step_ff      <= x_step_in;
         y_step_ff      <= y_step_in;
         points_left_ff <= points_left_in;
         cnt_ff         <= cnt_in;
         axis_ff        <= axis_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload and divider operands carry no reset.
   always_ff @(posedge clock) begin
      mag_y_ff    <= mag_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;
   assign rsp_last    = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // The divisor parked in the point counter is never zero while dividing.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (points_left_ff != '0))
      else $error("divider running with a zero step count");

   // The bit counter never runs past the last quotient bit.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (cnt_ff <= LAST_BIT))
      else $error("divider bit counter out of range");

   // An accepted next-point request on a live line produces a result and counts down.
   a_emit: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_command == CMD_NEXT) && (points_left_ff != '0))
      |=> (rsp_valid_ff && (points_left_ff == PL_W'($past(points_left_ff) - 1'b1))))
      else $error("next-point transfer did not emit and count down");

   // On an idle line a next-point request changes nothing and emits nothing new.
   a_idle: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_command == CMD_NEXT) && (points_left_ff == '0))
      |=> ((points_left_ff == '0) && $stable(x_accum_ff) && $stable(y_accum_ff)))
      else $error("idle next-point transfer changed line state");
`endif

endmodule : dda_line_rasterizer

`default_nettype wire
